// ===== sv/rncc_pkg.sv =====
package rncc_pkg;

  // Width of every count in a result; counts wrap at this width.
  localparam int COUNT_BITS = 17;
  localparam int VALUE_BITS_DEF = 16;
  localparam int OUT_W = ((4 * COUNT_BITS + 7) / 8) * 8;
  // Smallest prime, also the first trial divisor.
  localparam int FIRST_PRIME = 2;

  typedef struct packed {
    logic load;
    logic calc_par;
    logic sq_start;
    logic sq_sel_lo;
    logic sq_step;
    logic sq_keep;
    logic sq_fin;
    logic pr_init;
    logic rem_start;
    logic rem_step;
    logic d_next;
    logic v_next;
    logic prime_inc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic hi_lt2;
    logic dsq_gt_v;
    logic rem_zero;
    logic v_is_hi;
    logic out_busy;
  } sts_t;

endpackage

// ===== sv/rncc_ctrl.sv =====
module rncc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rncc_pkg::sts_t sts,
  output rncc_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PAR  = 4'd1;
  localparam logic [3:0] S_SQA  = 4'd2;
  localparam logic [3:0] S_SQB0 = 4'd3;
  localparam logic [3:0] S_SQB  = 4'd4;
  localparam logic [3:0] S_SQF  = 4'd5;
  localparam logic [3:0] S_PCHK = 4'd6;
  localparam logic [3:0] S_REM  = 4'd7;
  localparam logic [3:0] S_RTST = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_PAR;
        end
      end
      S_PAR: begin
        cmd.calc_par = 1'b1;
        cmd.sq_start = 1'b1;
        state_nxt = S_SQA;
      end
      S_SQA: begin
        cmd.sq_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_SQB0;
      end
      S_SQB0: begin
        cmd.sq_keep = 1'b1;
        cmd.sq_start = 1'b1;
        cmd.sq_sel_lo = 1'b1;
        state_nxt = S_SQB;
      end
      S_SQB: begin
        cmd.sq_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_SQF;
      end
      S_SQF: begin
        cmd.sq_fin = 1'b1;
        cmd.pr_init = 1'b1;
        state_nxt = sts.hi_lt2 ? S_OUT : S_PCHK;
      end
      S_PCHK: begin
        if (sts.dsq_gt_v) begin
          // No divisor up to the square root: the value is prime.
          cmd.prime_inc = 1'b1;
          if (sts.v_is_hi) begin
            state_nxt = S_OUT;
          end else begin
            cmd.v_next = 1'b1;
          end
        end else begin
          cmd.rem_start = 1'b1;
          state_nxt = S_REM;
        end
      end
      S_REM: begin
        cmd.rem_step = 1'b1;
        if (sts.cnt_last) state_nxt = S_RTST;
      end
      S_RTST: begin
        if (sts.rem_zero) begin
          if (sts.v_is_hi) begin
            state_nxt = S_OUT;
          end else begin
            cmd.v_next = 1'b1;
            state_nxt = S_PCHK;
          end
        end else begin
          cmd.d_next = 1'b1;
          state_nxt = S_PCHK;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // A new result must never overwrite one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded while output stalled");

  // A trial division runs only after the square-root bound was checked.
  a_rem_after_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_start |-> !sts.dsq_gt_v)
    else $error("trial division past the square-root bound");
`endif

endmodule

// ===== sv/rncc_dp.sv =====
module rncc_dp #(
  parameter int VALUE_BITS = rncc_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic signed [VALUE_BITS-1:0]       range_a,
  input  logic signed [VALUE_BITS-1:0]       range_b,
  input  rncc_pkg::cmd_t                     cmd,
  output rncc_pkg::sts_t                     sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [rncc_pkg::COUNT_BITS-1:0]    prime_count,
  output logic [rncc_pkg::COUNT_BITS-1:0]    square_count,
  output logic [rncc_pkg::COUNT_BITS-1:0]    even_count,
  output logic [rncc_pkg::COUNT_BITS-1:0]    odd_count
);

  localparam int VB = VALUE_BITS;
  localparam int CB = rncc_pkg::COUNT_BITS;
  localparam int RW = (VB + 1) / 2;
  localparam int SW = 2 * RW;
  localparam int XW = (VB + 2 > CB + 1) ? VB + 2 : CB + 1;
  localparam int CW = $clog2(VB);
  localparam logic [VB-1:0] TWO = VB'(rncc_pkg::FIRST_PRIME);
  localparam logic [VB-1:0] FOUR = VB'(rncc_pkg::FIRST_PRIME * rncc_pkg::FIRST_PRIME);

  logic signed [VB-1:0] lo_r, hi_r;
  logic [CB-1:0]        even_r, odd_r, square_r, prime_r;
  logic [CW-1:0]        cnt_r;

  // Square-root unit, one result bit per step.
  logic [SW-1:0]        sq_op_r;
  logic [RW:0]          sq_rem_r;
  logic [RW-1:0]        sq_root_r;
  logic [RW-1:0]        sqa_r;

  // Trial division state and the bit-serial remainder unit.
  logic [VB-1:0]        v_r, d_r, dsq_r, dv_r, rm_r;

  logic                 out_valid_r;
  logic [CB-1:0]        o_prime_r, o_square_r, o_even_r, o_odd_r;

  logic signed [VB-1:0] lo_ld, hi_ld;
  logic [XW-1:0]        hx, lx, ne, no;
  logic                 hi_neg, lo_pos;
  logic [VB-1:0]        sq_opnd;
  logic [RW+2:0]        sq_sh, sq_trial;
  logic [VB:0]          rm_sh;
  logic [CB-1:0]        sqa_ext, sqb_ext;

  assign lo_ld = (range_a > range_b) ? range_b : range_a;
  assign hi_ld = (range_a > range_b) ? range_a : range_b;

  // Evens in the range: half the length, rounded up when the range starts even.
  assign hx = {{(XW-VB){hi_r[VB-1]}}, hi_r};
  assign lx = {{(XW-VB){lo_r[VB-1]}}, lo_r};
  assign ne = hx - lx + {{(XW-2){1'b0}}, (lo_r[0] ? 2'd1 : 2'd2)};
  assign no = hx - lx + {{(XW-2){1'b0}}, (lo_r[0] ? 2'd2 : 2'd1)};

  assign hi_neg = hi_r[VB-1];
  assign lo_pos = !lo_r[VB-1] && (lo_r != '0);

  // The square count is isqrt(hi) + 1 less isqrt(lo - 1) + 1 where each applies.
  assign sq_opnd = cmd.sq_sel_lo ? (lo_pos ? VB'(lo_r - 1'b1) : '0)
                                 : (hi_neg ? '0 : VB'(hi_r));
  assign sq_sh    = {sq_rem_r, sq_op_r[SW-1:SW-2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  assign rm_sh = {rm_r, dv_r[VB-1]};

  assign sqa_ext = CB'(sqa_r);
  assign sqb_ext = CB'(sq_root_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r <= lo_ld;
      hi_r <= hi_ld;
    end
    if (cmd.calc_par) begin
      even_r <= ne[CB:1];
      odd_r  <= no[CB:1];
    end

    if (cmd.sq_start) begin
      sq_op_r   <= SW'(sq_opnd);
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      cnt_r     <= CW'(RW - 1);
    end else if (cmd.sq_step) begin
      sq_op_r <= {sq_op_r[SW-3:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_r  <= (RW+1)'(sq_sh - sq_trial);
        sq_root_r <= {sq_root_r[RW-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sq_sh[RW:0];
        sq_root_r <= {sq_root_r[RW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end else if (cmd.rem_start) begin
      rm_r  <= '0;
      dv_r  <= v_r;
      cnt_r <= CW'(VB - 1);
    end else if (cmd.rem_step) begin
      dv_r <= {dv_r[VB-2:0], 1'b0};
      if (rm_sh >= {1'b0, d_r}) begin
        rm_r <= VB'(rm_sh - {1'b0, d_r});
      end else begin
        rm_r <= rm_sh[VB-1:0];
      end
      cnt_r <= cnt_r - 1'b1;
    end

    if (cmd.sq_keep) sqa_r <= sq_root_r;
    if (cmd.sq_fin) begin
      if (hi_neg) begin
        square_r <= '0;
      end else if (lo_pos) begin
        square_r <= sqa_ext - sqb_ext;
      end else begin
        square_r <= sqa_ext + 1'b1;
      end
    end

    if (cmd.pr_init) begin
      prime_r <= '0;
      v_r     <= (lo_r > $signed(TWO)) ? VB'(lo_r) : TWO;
      d_r     <= TWO;
      dsq_r   <= FOUR;
    end else begin
      if (cmd.prime_inc) prime_r <= prime_r + 1'b1;
      if (cmd.v_next) begin
        v_r   <= v_r + 1'b1;
        d_r   <= TWO;
        dsq_r <= FOUR;
      end else if (cmd.d_next) begin
        // (d + 1)^2 = d^2 + 2d + 1
        d_r   <= d_r + 1'b1;
        dsq_r <= dsq_r + {d_r[VB-2:0], 1'b1};
      end
    end

    if (cmd.out_load) begin
      o_prime_r  <= prime_r;
      o_square_r <= square_r;
      o_even_r   <= even_r;
      o_odd_r    <= odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.cnt_last = (cnt_r == '0);
  assign sts.hi_lt2   = (hi_r < $signed(TWO));
  assign sts.dsq_gt_v = (dsq_r > v_r);
  assign sts.rem_zero = (rm_r == '0);
  assign sts.v_is_hi  = (v_r == VB'(hi_r));
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign prime_count  = o_prime_r;
  assign square_count = o_square_r;
  assign even_count   = o_even_r;
  assign odd_count    = o_odd_r;

`ifndef SYNTH
  // Even and odd counts of a contiguous range differ by at most one.
  a_par_balance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.calc_par |=> (even_r == odd_r) || (even_r == CB'(odd_r + 1'b1)) ||
                     (odd_r == CB'(even_r + 1'b1)))
    else $error("even and odd counts out of balance");

  // The partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rem_step |-> (rm_r < d_r))
    else $error("partial remainder not below divisor");
`endif

endmodule

// ===== sv/range_number_class_counter_top.sv =====
// Range number class counter.
// A request on the in_ channel carries two signed bounds; they may come in
// either order. For the closed range between them the block returns one result
// on the out_ channel with the number of primes, perfect squares (zero
// included), even values and odd values. Counts are 17 bits and wrap.
// Both channels are valid/ready streams; a request is taken when in_tvalid and
// in_tready are high at a rising edge, and the same holds for the result.
// One request is worked on at a time. The class counts are formed first, then
// the prime scan runs: each value from max(lo, 2) to hi is tried against
// divisors counting up from 2 to its square root, and every trial runs one
// division in the bit-serial remainder unit.
// The result sits in an output register, so in_tready rises again as soon as
// it is loaded, even while the receiver stalls; a following result waits in
// the controller until the previous one is taken.
// Reset (rst_n low, synchronous) drops any request in progress and any result
// not yet taken.
module range_number_class_counter_top #(
  parameter int VALUE_BITS = rncc_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // range_a, range_b
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // prime_count, square_count, even_count, odd_count
  output logic [rncc_pkg::OUT_W-1:0]             out_tdata
);

  localparam int CB = rncc_pkg::COUNT_BITS;

  rncc_pkg::cmd_t cmd;
  rncc_pkg::sts_t sts;
  logic [CB-1:0]  prime_count, square_count, even_count, odd_count;

  rncc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rncc_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .range_a      ($signed(in_tdata[VALUE_BITS-1:0])),
    .range_b      ($signed(in_tdata[2*VALUE_BITS-1:VALUE_BITS])),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .prime_count  (prime_count),
    .square_count (square_count),
    .even_count   (even_count),
    .odd_count    (odd_count)
  );

  assign out_tdata = rncc_pkg::OUT_W'({odd_count, even_count, square_count, prime_count});

endmodule
